[rtl/core/mlf_pkg.sv]
// ----------------------------------------------------------------------------
// mlf_pkg - shared types for the most/least frequent value block
// Cell chain commands, controller states and the sorted beat stream record.
// ----------------------------------------------------------------------------
package mlf_pkg;

  localparam int unsigned DATA_W = 32;

  // Command broadcast to every sorting cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_cmd_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD   = 2'd0,
    ST_DRAIN  = 2'd1,
    ST_FINISH = 2'd2
  } mlf_state_t;

  // One sorted value leaving the head of the chain
  typedef struct packed {
    logic                     vld;
    logic signed [DATA_W-1:0] value;
  } sorted_beat_t;

endpackage : mlf_pkg

[rtl/core/mlf_cell.sv]
// ----------------------------------------------------------------------------
// mlf_cell - one slot of the insertion sorting chain
// Holds one value; on insert it keeps, takes the new value or takes its left
// neighbour's value; on shift it takes its right neighbour's value.
// ----------------------------------------------------------------------------
module mlf_cell (
  input  logic                             clk,
  input  mlf_pkg::cell_cmd_t               cmd,
  input  logic                             occupied,
  input  logic signed [mlf_pkg::DATA_W-1:0] ins_value,
  input  logic                             left_gt,
  input  logic signed [mlf_pkg::DATA_W-1:0] left_value,
  input  logic signed [mlf_pkg::DATA_W-1:0] right_value,
  output logic                             gt,
  output logic signed [mlf_pkg::DATA_W-1:0] value
);
  import mlf_pkg::*;

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  // An empty slot counts as larger than any value
  assign gt    = !occupied || (value_r > ins_value);
  assign value = value_r;

  // Select the next slot content
  always_comb begin
    value_nxt = value_r;
    unique case (cmd)
      CELL_INSERT: begin
        if (gt) begin
          value_nxt = left_gt ? left_value : ins_value;
        end
      end
      CELL_SHIFT: value_nxt = right_value;
      CELL_HOLD:  value_nxt = value_r;
      default:    value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule : mlf_cell

[rtl/core/mlf_scan.sv]
// ----------------------------------------------------------------------------
// mlf_scan - run length tracker over the sorted stream
// Counts runs of equal values and keeps the longest and shortest run seen;
// the first run wins a tie, which is the smallest value.
// ----------------------------------------------------------------------------
module mlf_scan #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mlf_pkg::sorted_beat_t             beat,
  input  logic                              clear,
  output logic signed [mlf_pkg::DATA_W-1:0] most,
  output logic signed [mlf_pkg::DATA_W-1:0] least
);
  import mlf_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_ITEMS + 1);

  logic                     have_r,  have_nxt;
  logic                     any_r,   any_nxt;
  logic signed [DATA_W-1:0] cur_val_r,   cur_val_nxt;
  logic [LEN_W-1:0]         cur_len_r,   cur_len_nxt;
  logic signed [DATA_W-1:0] best_val_r,  best_val_nxt;
  logic [LEN_W-1:0]         best_len_r,  best_len_nxt;
  logic signed [DATA_W-1:0] worst_val_r, worst_val_nxt;
  logic [LEN_W-1:0]         worst_len_r, worst_len_nxt;

  logic                     best_upd, worst_upd;
  logic signed [DATA_W-1:0] cm_best_val, cm_worst_val;
  logic [LEN_W-1:0]         cm_best_len, cm_worst_len;

  // Fold the open run into the kept extremes
  always_comb begin
    best_upd     = !any_r || (cur_len_r > best_len_r);
    worst_upd    = !any_r || (cur_len_r < worst_len_r);
    cm_best_val  = best_upd  ? cur_val_r : best_val_r;
    cm_best_len  = best_upd  ? cur_len_r : best_len_r;
    cm_worst_val = worst_upd ? cur_val_r : worst_val_r;
    cm_worst_len = worst_upd ? cur_len_r : worst_len_r;
  end

  assign most  = cm_best_val;
  assign least = cm_worst_val;

  // Extend the open run or close it and start a new one
  always_comb begin
    have_nxt      = have_r;
    any_nxt       = any_r;
    cur_val_nxt   = cur_val_r;
    cur_len_nxt   = cur_len_r;
    best_val_nxt  = best_val_r;
    best_len_nxt  = best_len_r;
    worst_val_nxt = worst_val_r;
    worst_len_nxt = worst_len_r;
    priority if (clear) begin
      have_nxt = 1'b0;
      any_nxt  = 1'b0;
    end else if (beat.vld) begin
      if (have_r && (beat.value == cur_val_r)) begin
        cur_len_nxt = cur_len_r + LEN_W'(1);
      end else begin
        if (have_r) begin
          any_nxt       = 1'b1;
          best_val_nxt  = cm_best_val;
          best_len_nxt  = cm_best_len;
          worst_val_nxt = cm_worst_val;
          worst_len_nxt = cm_worst_len;
        end
        have_nxt    = 1'b1;
        cur_val_nxt = beat.value;
        cur_len_nxt = LEN_W'(1);
      end
    end else begin
      have_nxt = have_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      any_r  <= 1'b0;
    end else begin
      have_r <= have_nxt;
      any_r  <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_val_r   <= cur_val_nxt;
    cur_len_r   <= cur_len_nxt;
    best_val_r  <= best_val_nxt;
    best_len_r  <= best_len_nxt;
    worst_val_r <= worst_val_nxt;
    worst_len_r <= worst_len_nxt;
  end

`ifndef SYNTH
  // A run never grows beyond the store
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (cur_len_r != '0) && (cur_len_r <= LEN_W'(MAX_ITEMS)))
    else $error("run length out of range");
  // A cleared tracker holds no run
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> !have_r && !any_r)
    else $error("tracker not cleared");
  // Equal value extends the open run by one
  a_extend: assert property (@(posedge clk) disable iff (!rst_n)
    (!clear && beat.vld && have_r && (beat.value == cur_val_r))
      |=> cur_len_r == $past(cur_len_r) + LEN_W'(1))
    else $error("run not extended");
`endif

endmodule : mlf_scan

[rtl/core/most_least_frequent_value.sv]
// ----------------------------------------------------------------------------
// most_least_frequent_value - mode and least frequent value of a set
// Sorts each set in a chain of cells as it arrives, then shifts it out
// through a run tracker and reports the longest and shortest run.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                               | tlast/tuser
//  in_     | in  | [31:0] sample_value                 | tlast = end_of_set
//  out_    | out | [31:0] most_frequent,               | tuser = overflowed
//          |     | [63:32] least_frequent              |
//
//  Loading takes one beat per cycle: each beat lands in the cell chain at once.
//  After the beat with tlast the chain shifts out its held values, one per
//  cycle, then the finish state folds the last run; in_tready is low for the
//  drain and the fold. A result waits in the output register; a stalled output
//  holds the fold, and loading with it. Beats beyond MAX_ITEMS are dropped and
//  flagged. Reset leaves the chain empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module most_least_frequent_value #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] sample_value
  input  logic        in_tlast,   // end_of_set
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] most_frequent, [63:32] least_frequent
  output logic        out_tuser   // overflowed
);
  import mlf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  mlf_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             fin_ovf_r, fin_ovf_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [DATA_W-1:0] out_most_r, out_least_r;
  logic             out_ovf_r;

  logic             in_acc;
  logic             full;
  logic             out_free;
  logic             load_out;
  cell_cmd_t        cmd;
  sorted_beat_t     head_beat;
  logic signed [DATA_W-1:0] ins_value;
  logic signed [DATA_W-1:0] res_most, res_least;

  logic [MAX_ITEMS-1:0]     occ;
  logic [MAX_ITEMS-1:0]     gt;
  logic signed [DATA_W-1:0] cval [MAX_ITEMS];

  assign ins_value = $signed(in_tdata);
  assign full      = (count_r == CNT_W'(MAX_ITEMS));
  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign load_out  = (state_r == ST_FINISH) && out_free;

  // Mark the slots that hold values
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_occ
    assign occ[i] = (count_r > CNT_W'(i));
  end

  // Sorting chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    mlf_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occ[i]),
      .ins_value   (ins_value),
      .left_gt     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .left_value  ((i == 0) ? ins_value : cval[(i == 0) ? 0 : i-1]),
      .right_value ((i == MAX_ITEMS-1) ? ins_value
                                       : cval[(i == MAX_ITEMS-1) ? i : i+1]),
      .gt          (gt[i]),
      .value       (cval[i])
    );
  end

  // Feed the head of the chain to the run tracker while draining
  assign head_beat.vld   = (state_r == ST_DRAIN);
  assign head_beat.value = cval[0];

  mlf_scan #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .beat  (head_beat),
    .clear (load_out),
    .most  (res_most),
    .least (res_least)
  );

  // Controller: next state, chain command and counters
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    fin_ovf_nxt = fin_ovf_r;
    cmd         = CELL_HOLD;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            cmd       = CELL_INSERT;
            count_nxt = count_r + CNT_W'(1);
          end
          if (in_tlast) begin
            fin_ovf_nxt = ovf_r || full;
            ovf_nxt     = 1'b0;
            state_nxt   = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        cmd       = CELL_SHIFT;
        count_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_vld_nxt = out_vld_r;
    priority if (load_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      fin_ovf_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      fin_ovf_r <= fin_ovf_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_most_r  <= res_most;
      out_least_r <= res_least;
      out_ovf_r   <= fin_ovf_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_least_r, out_most_r};
  assign out_tuser  = out_ovf_r;

`ifndef SYNTH
  // Fill level never exceeds the chain
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");
  // Draining always has a value left to shift out
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (count_r != '0))
    else $error("drain with empty chain");
  // The chain is empty by the fold cycle
  a_finish_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (count_r == '0))
    else $error("chain not emptied");
  // A dropped beat inside a set raises the flag
  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full && !in_tlast) |=> ovf_r)
    else $error("drop not flagged");
`endif

endmodule : most_least_frequent_value

[tb/tb_most_least_frequent_value.sv]
// ----------------------------------------------------------------------------
// tb_most_least_frequent_value - self-checking bench for the mode/antimode block
// Streams signed sets into the sorter, predicts the most and least frequent
// value of every set (smallest value wins a tie, overflow flagged past 64
// entries) and checks each result beat against the prediction in order.
// ----------------------------------------------------------------------------

// Result of one set as the block should report it
typedef struct packed {
  logic signed [31:0] most;
  logic signed [31:0] least;
  logic               ovf;
} mode_result_t;

// Sorted copy of the current set plus the queue of outstanding set results
class mode_scoreboard;
  localparam int unsigned DEPTH = 64;

  logic signed [31:0] sorted_vals [DEPTH];
  int unsigned        held;
  bit                 dropped;
  mode_result_t       expected_modes [$];
  int unsigned        fails;

  function new();
    held    = 0;
    dropped = 1'b0;
    fails   = 0;
  endfunction

  function int unsigned pending();
    return expected_modes.size();
  endfunction

  // Insert an accepted sample; on the closing beat fold the runs into a result
  function void note_sample(logic signed [31:0] value, logic last);
    int unsigned  pos;
    int unsigned  i;
    int unsigned  j;
    int unsigned  run;
    int unsigned  best;
    int unsigned  worst;
    mode_result_t res;
    if (held == DEPTH) begin
      dropped = 1'b1;
    end else begin
      pos = held;
      while (pos > 0 && sorted_vals[pos-1] > value) begin
        sorted_vals[pos] = sorted_vals[pos-1];
        pos--;
      end
      sorted_vals[pos] = value;
      held++;
    end
    if (last) begin
      res   = '0;
      i     = 0;
      best  = 0;
      worst = 0;
      // walk runs of equal values; strict compares keep the smallest on a tie
      while (i < held) begin
        j = i + 1;
        while (j < held && sorted_vals[j] == sorted_vals[i]) j++;
        run = j - i;
        if (i == 0 || run > best) begin
          best     = run;
          res.most = sorted_vals[i];
        end
        if (i == 0 || run < worst) begin
          worst     = run;
          res.least = sorted_vals[i];
        end
        i = j;
      end
      res.ovf = dropped;
      expected_modes.push_back(res);
      held    = 0;
      dropped = 1'b0;
    end
  endfunction

  // Compare a result beat with the oldest outstanding set
  function void check_result(logic [63:0] data, logic ovf);
    mode_result_t want;
    if (expected_modes.size() == 0) begin
      fails++;
      $display("%0t: unexpected result beat: most %0d, least %0d, overflowed %0b",
               $time, $signed(data[31:0]), $signed(data[63:32]), ovf);
      return;
    end
    want = expected_modes.pop_front();
    if ($signed(data[31:0]) !== want.most) begin
      fails++;
      $display("%0t: most_frequent mismatch: expected %0d, actual %0d",
               $time, want.most, $signed(data[31:0]));
    end
    if ($signed(data[63:32]) !== want.least) begin
      fails++;
      $display("%0t: least_frequent mismatch: expected %0d, actual %0d",
               $time, want.least, $signed(data[63:32]));
    end
    if (ovf !== want.ovf) begin
      fails++;
      $display("%0t: overflowed mismatch: expected %0b, actual %0b",
               $time, want.ovf, ovf);
    end
  endfunction
endclass

module tb_most_least_frequent_value;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned TARGET_ITEMS = 800;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned STALL_CYCLES = 400;
  localparam int unsigned DRAIN_WAIT   = CAPACITY + 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tuser;

  mode_scoreboard tally = new();
  int unsigned    sent_items = 0;

  always #5 clk = ~clk;

  most_least_frequent_value #(
    .MAX_ITEMS (CAPACITY)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Offer one sample beat after an optional gap and hold it until accepted
  task automatic send_beat(input logic [31:0] value, input logic last, input bit eager);
    int unsigned gap;
    gap = eager ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tally.note_sample(value, last);
    sent_items++;
  endtask

  // Send one random set; the value mix decides how many repeats it carries
  task automatic send_set(input int unsigned len, input bit eager);
    int unsigned kind;
    logic [31:0] pool [4];
    logic [31:0] value;
    kind = $urandom_range(0, 3);
    for (int p = 0; p < 4; p++) pool[p] = $urandom;
    for (int unsigned n = 0; n < len; n++) begin
      case (kind)
        0: begin
          value = $urandom;
        end
        1: begin
          value = $urandom_range(0, 6) - 3;
        end
        2: begin
          case ($urandom_range(0, 3))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'h0000_0000;
            default: value = 32'hFFFF_FFFF;
          endcase
        end
        default: begin
          value = pool[$urandom_range(0, 3)];
        end
      endcase
      send_beat(value, n == len - 1, eager);
    end
  endtask

  // Result sink: random back-pressure, one long hold early on, gap-free stretches
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken == 12)
        gap = STALL_CYCLES;
      else if (taken % 20 < 5)
        gap = 0;
      else
        gap = $urandom_range(0, 12);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      tally.check_result(out_tdata, out_tuser);
      taken++;
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Reset, directed sets, random sets, drain and verdict
  initial begin : stimulus
    int unsigned set_idx;
    int unsigned len;
    bit          paused;
    set_idx = 0;
    paused  = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element sets at both extremes
    send_beat(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_beat(32'h8000_0000, 1'b1, 1'b0);
    // all distinct: smallest wins both ties
    send_beat(32'h0000_0000, 1'b0, 1'b1);
    send_beat(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_beat(32'h8000_0000, 1'b0, 1'b1);
    send_beat(32'h7FFF_FFFF, 1'b1, 1'b1);
    // tie on the longest run, distinct shortest
    send_beat(32'd5, 1'b0, 1'b0);
    send_beat(32'd5, 1'b0, 1'b0);
    send_beat(32'd3, 1'b0, 1'b0);
    send_beat(32'd3, 1'b0, 1'b0);
    send_beat(32'd7, 1'b1, 1'b0);
    // one run only
    send_beat(32'd9, 1'b0, 1'b1);
    send_beat(32'd9, 1'b0, 1'b1);
    send_beat(32'd9, 1'b1, 1'b1);
    // distinct longest, distinct shortest, unsorted arrival
    send_beat(-32'sd2, 1'b0, 1'b0);
    send_beat(32'd4, 1'b0, 1'b0);
    send_beat(32'd4, 1'b0, 1'b0);
    send_beat(32'd4, 1'b0, 1'b0);
    send_beat(-32'sd2, 1'b0, 1'b0);
    send_beat(32'd1, 1'b1, 1'b0);
    // every run the same length
    send_beat(32'd2, 1'b0, 1'b1);
    send_beat(32'd1, 1'b0, 1'b1);
    send_beat(32'd1, 1'b0, 1'b1);
    send_beat(32'd2, 1'b0, 1'b1);
    send_beat(32'd3, 1'b0, 1'b1);
    send_beat(32'd3, 1'b1, 1'b1);

    // random sets; the first three fill the store exactly, drop the closing beat
    // and drop many beats
    while (sent_items < TARGET_ITEMS) begin
      case (set_idx)
        0: len = CAPACITY;
        1: len = CAPACITY + 1;
        2: len = CAPACITY + 16;
        default: begin
          if ($urandom_range(0, 11) == 0)
            len = $urandom_range(CAPACITY - 4, CAPACITY + 6);
          else
            len = $urandom_range(1, 12);
        end
      endcase
      send_set(len, set_idx % 7 == 0);
      set_idx++;
      // hold the input until the block has delivered everything
      if (!paused && sent_items >= TARGET_ITEMS / 2) begin
        paused = 1'b1;
        in_tvalid <= 1'b0;
        while (tally.pending() != 0) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (tally.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tally.fails == 0 && tally.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[most_least_frequent_value.f]
rtl/core/mlf_pkg.sv
rtl/core/mlf_cell.sv
rtl/core/mlf_scan.sv
rtl/core/most_least_frequent_value.sv
tb/tb_most_least_frequent_value.sv
